[rtl/mck_pkg.sv]
package mck_pkg;

    localparam int CODE_ENTRIES = 43;

    localparam int CHAR_W     = 8;
    localparam int UNIT_W     = 14;
    localparam int DUR_W      = 16;
    localparam int IDX_W      = 6;
    localparam int CODE_W     = 8;
    localparam int COUNT_W    = 3;
    localparam int UNITS_W    = 3;
    localparam int PROD_W     = UNIT_W + UNITS_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CHAR_W-1:0] BASE_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    localparam logic [UNITS_W-1:0] UNITS_DOT  = 3'd1;
    localparam logic [UNITS_W-1:0] UNITS_DASH = 3'd3;
    localparam logic [UNITS_W-1:0] UNITS_GAP  = 3'd3;
    localparam logic [UNITS_W-1:0] UNITS_WORD = 3'd7;

    localparam logic [UNIT_W-1:0] UNIT_LENGTH_RESET = 14'd128;

    // word index within the register map
    localparam logic REG_UNIT_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ON,
        ST_OFF,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        PER_MARK,
        PER_SPACE,
        PER_FINAL
    } period_t;

    typedef struct packed {
        logic    load;
        logic    advance;
        logic    strobe;
        period_t period;
    } cmd_t;

    typedef struct packed {
        logic empty_code;
        logic last_elem;
    } status_t;

    function automatic logic [CODE_W-1:0] code_rom(input logic [IDX_W-1:0] idx);
        logic [CODE_W-1:0] c;
        case (idx)
            6'd0:    c = 8'hBF;
            6'd1:    c = 8'hBE;
            6'd2:    c = 8'hBC;
            6'd3:    c = 8'hB8;
            6'd4:    c = 8'hB0;
            6'd5:    c = 8'hA0;
            6'd6:    c = 8'hA1;
            6'd7:    c = 8'hA3;
            6'd8:    c = 8'hA7;
            6'd9:    c = 8'hAF;
            6'd17:   c = 8'h42;
            6'd18:   c = 8'h81;
            6'd19:   c = 8'h85;
            6'd20:   c = 8'h61;
            6'd21:   c = 8'h20;
            6'd22:   c = 8'h84;
            6'd23:   c = 8'h63;
            6'd24:   c = 8'h80;
            6'd25:   c = 8'h40;
            6'd26:   c = 8'h8E;
            6'd27:   c = 8'h65;
            6'd28:   c = 8'h82;
            6'd29:   c = 8'h43;
            6'd30:   c = 8'h41;
            6'd31:   c = 8'h67;
            6'd32:   c = 8'h86;
            6'd33:   c = 8'h8B;
            6'd34:   c = 8'h62;
            6'd35:   c = 8'h60;
            6'd36:   c = 8'h21;
            6'd37:   c = 8'h64;
            6'd38:   c = 8'h88;
            6'd39:   c = 8'h66;
            6'd40:   c = 8'h89;
            6'd41:   c = 8'h8D;
            6'd42:   c = 8'h83;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/morse_character_keyer.sv]
// Morse keyer: start with busy low takes one ASCII character, and the block then
// puts out one lamp period per clock cycle on the result ports, each marked by
// strobe for exactly one cycle; the receiver must take every result as it comes.
// A character of n elements gives 2n+1 results (mark and space per element, then
// the final period), set by the element sequencer giving one period a cycle; a
// space or a character without elements gives only the final period, and the
// longest code has five elements. last_of_run marks a character's final period.
// Users write unit_length over the apb port only while busy is low; not enforced.
module morse_character_keyer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mck_pkg::CHAR_W-1:0]       character,
    output logic                             busy,
    output logic                             strobe,
    output logic                             lamp_on,
    output logic [mck_pkg::DUR_W-1:0]        duration_ticks,
    output logic                             last_of_run,
    output logic                             unsupported,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mck_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mck_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mck_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import mck_pkg::*;

    logic [UNIT_W-1:0] unit_length_reg;
    logic [UNIT_W-1:0] unit_length_next;
    logic              reg_hit;
    cmd_t              cmd;
    status_t           status;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_UNIT_LENGTH);

    always_comb
    begin
        unit_length_next = unit_length_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            unit_length_next = pwdata[UNIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_length_reg <= UNIT_LENGTH_RESET;
        end
        else
        begin
            unit_length_reg <= unit_length_next;
        end
    end

    assign prdata = reg_hit ? APB_DATA_W'(unit_length_reg) : '0;

    mck_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mck_dp u_dp (
        .clk            (clk),
        .character      (character),
        .unit_length    (unit_length_reg),
        .cmd            (cmd),
        .status         (status),
        .lamp_on        (lamp_on),
        .duration_ticks (duration_ticks),
        .last_of_run    (last_of_run),
        .unsupported    (unsupported)
    );

    assign strobe = cmd.strobe;

    // an accepted item always yields a result in the very next cycle
    a_accept_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> strobe)
        else $error("no result after accepted item");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_of_run) |=> !busy)
        else $error("still busy after last result");

    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result outside a run");

    a_unsup_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && unsupported) |-> (last_of_run && !lamp_on))
        else $error("unsupported flag on a non-gap period");

endmodule

[rtl/mck_ctrl.sv]
module mck_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mck_pkg::status_t status,
    output mck_pkg::cmd_t    cmd,
    output logic             busy
);
    import mck_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = status.empty_code ? ST_FINAL : ST_ON;
                end
            end
            ST_ON:
            begin
                state_next = ST_OFF;
            end
            ST_OFF:
            begin
                state_next = status.last_elem ? ST_FINAL : ST_ON;
            end
            ST_FINAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        cmd.strobe  = 1'b0;
        cmd.period  = PER_FINAL;
        busy        = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_ON:
            begin
                cmd.strobe = 1'b1;
                cmd.period = PER_MARK;
            end
            ST_OFF:
            begin
                cmd.strobe  = 1'b1;
                cmd.period  = PER_SPACE;
                cmd.advance = 1'b1;
            end
            ST_FINAL:
            begin
                cmd.strobe = 1'b1;
                cmd.period = PER_FINAL;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

[rtl/mck_dp.sv]
module mck_dp (
    input  logic                         clk,
    input  logic [mck_pkg::CHAR_W-1:0]   character,
    input  logic [mck_pkg::UNIT_W-1:0]   unit_length,
    input  mck_pkg::cmd_t                cmd,
    output mck_pkg::status_t             status,
    output logic                         lamp_on,
    output logic [mck_pkg::DUR_W-1:0]    duration_ticks,
    output logic                         last_of_run,
    output logic                         unsupported
);
    import mck_pkg::*;

    logic [CODE_W-1:0]  code_reg;
    logic [CODE_W-1:0]  code_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [UNITS_W-1:0] final_units_reg;
    logic [UNITS_W-1:0] final_units_next;
    logic               unsup_reg;
    logic               unsup_next;

    logic [CHAR_W-1:0]  offset;
    logic               is_space;
    logic               no_entry;
    logic [CODE_W-1:0]  in_code;
    logic [UNITS_W-1:0] units;
    logic [PROD_W-1:0]  product;

    // decode of the incoming character
    always_comb
    begin
        offset   = character - BASE_CHAR;
        is_space = (character == SPACE_CHAR);
        no_entry = !is_space &&
                   ((character < BASE_CHAR) || (offset >= CHAR_W'(CODE_ENTRIES)));
        if (is_space || no_entry)
        begin
            in_code = '0;
        end
        else
        begin
            in_code = code_rom(offset[IDX_W-1:0]);
        end
    end

    assign status.empty_code = (in_code[CODE_W-1 -: COUNT_W] == '0);
    assign status.last_elem  = (count_reg == COUNT_W'(1));

    always_comb
    begin
        code_next        = code_reg;
        count_next       = count_reg;
        final_units_next = final_units_reg;
        unsup_next       = unsup_reg;
        if (cmd.load)
        begin
            code_next        = in_code;
            count_next       = in_code[CODE_W-1 -: COUNT_W];
            final_units_next = is_space ? UNITS_WORD : UNITS_GAP;
            unsup_next       = no_entry;
        end
        else if (cmd.advance)
        begin
            // whole byte shifts, as the element bits are consumed from bit 0
            code_next  = code_reg >> 1;
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg        <= code_next;
        count_reg       <= count_next;
        final_units_reg <= final_units_next;
        unsup_reg       <= unsup_next;
    end

    always_comb
    begin
        case (cmd.period)
            PER_MARK:  units = code_reg[0] ? UNITS_DASH : UNITS_DOT;
            PER_SPACE: units = UNITS_DOT;
            PER_FINAL: units = final_units_reg;
            default:   units = final_units_reg;
        endcase
    end

    assign product = PROD_W'(units) * PROD_W'(unit_length);

    always_comb
    begin
        lamp_on        = cmd.strobe && (cmd.period == PER_MARK);
        last_of_run    = cmd.strobe && (cmd.period == PER_FINAL);
        unsupported    = cmd.strobe && (cmd.period == PER_FINAL) && unsup_reg;
        duration_ticks = '0;
        if (cmd.strobe)
        begin
            // saturate at the top of the 16 bit range
            if (product[PROD_W-1:DUR_W] != '0)
            begin
                duration_ticks = '1;
            end
            else
            begin
                duration_ticks = product[DUR_W-1:0];
            end
        end
    end

endmodule
